[rtl/core/kmst_pkg.sv]
// Package for the Kruskal spanning-forest weight core.
// Holds widths, defaults and the state enum.
package kmst_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxEdgesDef    = 256;
  localparam int unsigned WeightBitsDef  = 16;

  localparam int unsigned NodeW   = 6;
  localparam int unsigned InWeightW = 16;
  localparam int unsigned SumW    = 22;
  localparam int unsigned TakenW  = 6;
  localparam int unsigned VcountW = 7;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_UF_INIT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_FIND,
    ST_COMPRESS,
    ST_UNION,
    ST_SIZE_WR,
    ST_OUT
  } state_e;

endpackage

[rtl/core/kmst_edge_mem.sv]
// Edge store: synchronous single-write, single-read memory with registered read data.
// Depends on kmst_pkg for the default depth MaxEdgesDef.
module kmst_edge_mem
  import kmst_pkg::*;
#(
  parameter int unsigned Depth = MaxEdgesDef,
  parameter int unsigned Width = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/kmst_uf_mem.sv]
// Union-find store: parent and tree size per vertex, one synchronous memory.
// Depends on kmst_pkg for the default depth MaxVerticesDef.
module kmst_uf_mem
  import kmst_pkg::*;
#(
  parameter int unsigned Depth = MaxVerticesDef,
  parameter int unsigned Width = 13
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/kruskal_mst_weight_core.sv]
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tdata: node_a[5:0] node_b[11:6] weight[27:12], pad; tlast: last_edge
// m_axis   | out | tdata: total_weight[21:0] edges_taken[27:22] edges_dropped[28], pad
// cfg      | in  | vertex_count[6:0], write when cfg_we_i
// Edges load one per cycle while in the load state. After the last edge the input
// stalls: the insertion sort orders the stored edges by weight, node_a, node_b,
// union-find init writes all MAX_VERTICES entries, and each stored edge is read
// and checked; for an in-range edge each endpoint's path is walked to its root
// and compressed, then differing roots are joined by size and the size written.
// Reset clears control state and sets vertex_count to 64; memories are rewritten
// before each use. A result waits in the output register while tready is low;
// loading goes on meanwhile and only the next result stalls behind it.
module kruskal_mst_weight_core
  import kmst_pkg::*;
#(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned MaxEdges    = MaxEdgesDef,
  parameter int unsigned WeightBits  = WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [VcountW-1:0] cfg_wdata_i,    // vertex_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // node_a, node_b, weight, zero pad
  input  logic               s_axis_tlast,   // last_edge
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata    // total_weight, edges_taken, edges_dropped, pad
);

  localparam int unsigned EAW = $clog2(MaxEdges);
  localparam int unsigned FW  = $clog2(MaxEdges + 1);
  localparam int unsigned VAW = $clog2(MaxVertices);
  localparam int unsigned VCW = $clog2(MaxVertices + 1);
  localparam int unsigned CW  = (FW > VCW) ? FW : VCW;
  localparam int unsigned NVW = (VCW > VcountW) ? VCW : VcountW;
  localparam int unsigned EW  = 2 * NodeW + WeightBits;
  localparam int unsigned SZW = VCW;
  localparam int unsigned UW  = VAW + SZW;

  typedef struct packed {
    logic [WeightBits-1:0] w;
    logic [NodeW-1:0]      a;
    logic [NodeW-1:0]      b;
  } edge_t;

  state_e state_q, state_d;

  logic [VcountW-1:0] vcount_q;
  logic [FW-1:0]      fill_q, fill_d;
  logic               ovf_q, ovf_d;
  logic [CW-1:0]      i_q, i_d;
  logic [FW-1:0]      j_q, j_d;
  edge_t              key_q, key_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [TakenW-1:0]  taken_q, taken_d;
  logic [VAW-1:0]     x_q, x_d, cur_q, cur_d, r_q, r_d;
  logic [SZW-1:0]     rsz_q, rsz_d;
  logic               is_b_q, is_b_d;
  logic [VAW-1:0]     root_a_q, root_a_d;
  logic [SZW-1:0]     size_a_q, size_a_d;
  logic               res_v_q, res_v_d;
  logic [31:0]        res_q, res_d;

  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  edge_t          e_wdata, e_rdata;
  logic           u_we;
  logic [VAW-1:0] u_waddr, u_raddr;
  logic [UW-1:0]  u_wdata, u_rdata;
  logic [VAW-1:0] u_par;
  logic [SZW-1:0] u_sz;
  logic [FW-1:0]  j_m1, j_m2;

  kmst_edge_mem #(.Depth(MaxEdges), .Width(EW)) u_edge_mem (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  kmst_uf_mem #(.Depth(MaxVertices), .Width(UW)) u_uf_mem (
    .clk_i, .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i(u_raddr), .rdata_o(u_rdata)
  );

  assign u_par = u_rdata[UW-1:SZW];
  assign u_sz  = u_rdata[SZW-1:0];
  assign j_m1  = j_q - FW'(1);
  assign j_m2  = j_q - FW'(2);

  // effective vertex count, clamped to 1..MaxVertices
  logic [NVW-1:0] nv;
  always_comb begin
    if (vcount_q == '0) nv = NVW'(1);
    else if (NVW'(vcount_q) > NVW'(MaxVertices)) nv = NVW'(MaxVertices);
    else nv = NVW'(vcount_q);
  end

  edge_t in_edge;
  assign in_edge.a = s_axis_tdata[NodeW-1:0];
  assign in_edge.b = s_axis_tdata[2*NodeW-1:NodeW];
  assign in_edge.w = s_axis_tdata[2*NodeW +: WeightBits];

  logic key_before;
  assign key_before = (key_q.w != e_rdata.w) ? (key_q.w < e_rdata.w) :
                      (key_q.a != e_rdata.a) ? (key_q.a < e_rdata.a) :
                      (key_q.b < e_rdata.b);

  logic in_acc;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = res_q;

  logic [SumW:0] sum_add;
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(key_q.w);

  always_comb begin
    state_d = state_q; fill_d = fill_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q;
    key_d = key_q; sum_d = sum_q; taken_d = taken_q; x_d = x_q; cur_d = cur_q;
    r_d = r_q; rsz_d = rsz_q; is_b_d = is_b_q; root_a_d = root_a_q;
    size_a_d = size_a_q; res_v_d = res_v_q; res_d = res_q;
    e_we = 1'b0; e_waddr = '0; e_wdata = in_edge; e_raddr = '0;
    u_we = 1'b0; u_waddr = '0; u_wdata = '0; u_raddr = x_q;
    if (m_axis_tvalid && m_axis_tready) res_v_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (fill_q < FW'(MaxEdges)) begin
            e_we = 1'b1; e_waddr = fill_q[EAW-1:0];
            fill_d = fill_q + FW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            i_d = CW'(1); state_d = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        if (i_q >= CW'(fill_q)) begin
          i_d = '0; state_d = ST_UF_INIT;
        end else begin
          e_raddr = i_q[EAW-1:0];
          j_d = FW'(i_q); state_d = ST_SORT_KEY;
        end
      end
      ST_SORT_KEY: begin
        key_d = e_rdata;
        e_raddr = j_m1[EAW-1:0];
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // e_rdata holds entry j-1
        e_we = 1'b1; e_waddr = j_q[EAW-1:0];
        if (j_q != '0 && key_before) begin
          // shift entry j-1 up, fetch j-2
          e_wdata = e_rdata;
          j_d = j_m1;
          e_raddr = j_m2[EAW-1:0];
        end else begin
          e_wdata = key_q;
          i_d = i_q + CW'(1); state_d = ST_SORT_RD;
        end
      end
      ST_UF_INIT: begin
        u_we = 1'b1; u_waddr = i_q[VAW-1:0];
        u_wdata = {i_q[VAW-1:0], SZW'(1)};
        if (i_q == CW'(MaxVertices - 1)) begin
          i_d = '0; sum_d = '0; taken_d = '0; state_d = ST_EDGE_RD;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      ST_EDGE_RD: begin
        if (i_q >= CW'(fill_q)) begin
          state_d = ST_OUT;
        end else begin
          e_raddr = i_q[EAW-1:0]; state_d = ST_EDGE_CHK;
        end
      end
      ST_EDGE_CHK: begin
        key_d = e_rdata;
        if (NVW'(e_rdata.a) >= nv || NVW'(e_rdata.b) >= nv) begin
          i_d = i_q + CW'(1); state_d = ST_EDGE_RD;
        end else begin
          x_d = VAW'(e_rdata.a); cur_d = VAW'(e_rdata.a); u_raddr = VAW'(e_rdata.a);
          is_b_d = 1'b0; state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        // u_rdata holds the entry of cur_q; walk up to the root
        if (u_par != cur_q) begin
          cur_d = u_par; u_raddr = u_par;
        end else begin
          r_d = cur_q; rsz_d = u_sz; u_raddr = x_q; state_d = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        // u_rdata holds the entry of x_q; point the path straight at the root
        if (x_q == r_q || u_par == r_q) begin
          if (!is_b_q) begin
            root_a_d = r_q; size_a_d = rsz_q; is_b_d = 1'b1;
            x_d = VAW'(key_q.b); cur_d = VAW'(key_q.b); u_raddr = VAW'(key_q.b);
            state_d = ST_FIND;
          end else begin
            state_d = ST_UNION;
          end
        end else begin
          u_we = 1'b1; u_waddr = x_q; u_wdata = {r_q, u_sz};
          x_d = u_par; u_raddr = u_par;
        end
      end
      ST_UNION: begin
        // roots: root_a_q/size_a_q for node_a, r_q/rsz_q for node_b
        if (root_a_q == r_q) begin
          i_d = i_q + CW'(1); state_d = ST_EDGE_RD;
        end else begin
          sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
          taken_d = taken_q + TakenW'(1);
          u_we = 1'b1;
          if (size_a_q < rsz_q) begin
            u_waddr = root_a_q; u_wdata = {r_q, size_a_q};
            root_a_d = r_q;
          end else begin
            u_waddr = r_q; u_wdata = {root_a_q, rsz_q};
          end
          // root_a now names the surviving root, size_a its new size
          size_a_d = size_a_q + rsz_q;
          state_d = ST_SIZE_WR;
        end
      end
      ST_SIZE_WR: begin
        u_we = 1'b1; u_waddr = root_a_q; u_wdata = {root_a_q, size_a_q};
        i_d = i_q + CW'(1); state_d = ST_EDGE_RD;
      end
      ST_OUT: begin
        // hold until the previous result has left
        if (!res_v_q || m_axis_tready) begin
          res_v_d = 1'b1;
          res_d = {3'b000, ovf_q, taken_q, sum_q};
          fill_d = '0; ovf_d = 1'b0; state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      vcount_q <= VcountW'(MaxVerticesDef);
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      key_q    <= '0;
      sum_q    <= '0;
      taken_q  <= '0;
      x_q      <= '0;
      cur_q    <= '0;
      r_q      <= '0;
      rsz_q    <= '0;
      is_b_q   <= 1'b0;
      root_a_q <= '0;
      size_a_q <= '0;
      res_v_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      key_q    <= key_d;
      sum_q    <= sum_d;
      taken_q  <= taken_d;
      x_q      <= x_d;
      cur_q    <= cur_d;
      r_q      <= r_d;
      rsz_q    <= rsz_d;
      is_b_q   <= is_b_d;
      root_a_q <= root_a_d;
      size_a_q <= size_a_d;
      res_v_q  <= res_v_d;
      res_q    <= res_d;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MaxEdges));
  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_LOAD);
  a_sort_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT_CMP |-> CW'(j_q) <= i_q);

endmodule

[tb/sv/tb_kruskal_mst_weight_core.sv]
// Testbench for kruskal_mst_weight_core: streams edge sets, predicts the forest
// weight, the accepted edge count and the overflow flag. Depends on kmst_pkg.
`timescale 1ns / 1ps
module tb_kruskal_mst_weight_core
  import kmst_pkg::*;
();

  localparam int unsigned IdleLimit = 400000;
  localparam int unsigned Capacity  = MaxEdgesDef;

  typedef struct packed {
    logic [NodeW-1:0]     a;
    logic [NodeW-1:0]     b;
    logic [InWeightW-1:0] w;
  } span_edge_t;

  typedef struct packed {
    logic [SumW-1:0]   total;
    logic [TakenW-1:0] taken;
    logic              dropped;
  } forest_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;

  kruskal_mst_weight_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Mirror of the block: pending graph and the vertex count register.
  span_edge_t  graph_q[$];
  bit          graph_overflow;
  logic [6:0]  vcount_cfg;
  forest_t     forest_q[$];

  int unsigned src_idle, snk_stall, hold_cycles;
  int unsigned mismatches, results_seen, edges_sent, graphs_sent;
  int unsigned idle_count;
  bit          in_hs, out_hs, timed_out;
  logic [31:0] out_data;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Kruskal over the stored graph: sort by weight, node_a, node_b, then union by size.
  function automatic forest_t kruskal_forest(span_edge_t es[$], bit ovf, logic [6:0] vc);
    span_edge_t key;
    int         parent[MaxVerticesDef];
    int         tsize[MaxVerticesDef];
    int         nv, j, ra, rb, r, x, nxt;
    longint     sum;
    int         cnt;
    forest_t    res;
    nv = (vc == 0) ? 1 : (vc > MaxVerticesDef) ? MaxVerticesDef : int'(vc);
    for (int i = 1; i < es.size(); i++) begin
      key = es[i];
      j = i;
      while (j > 0 && ({key.w, key.a, key.b} < {es[j-1].w, es[j-1].a, es[j-1].b})) begin
        es[j] = es[j-1];
        j--;
      end
      es[j] = key;
    end
    for (int i = 0; i < MaxVerticesDef; i++) begin
      parent[i] = i;
      tsize[i] = 1;
    end
    sum = 0;
    cnt = 0;
    foreach (es[i]) begin
      if (es[i].a >= nv || es[i].b >= nv) continue;
      for (int k = 0; k < 2; k++) begin
        x = (k == 0) ? int'(es[i].a) : int'(es[i].b);
        r = x;
        while (parent[r] != r) r = parent[r];
        while (x != r) begin
          nxt = parent[x];
          parent[x] = r;
          x = nxt;
        end
        if (k == 0) ra = r; else rb = r;
      end
      if (ra == rb) continue;
      sum += es[i].w;
      if (sum > SumMax) sum = SumMax;
      cnt++;
      if (tsize[ra] < tsize[rb]) begin
        parent[ra] = rb;
        tsize[rb] += tsize[ra];
      end else begin
        parent[rb] = ra;
        tsize[ra] += tsize[rb];
      end
    end
    res.total = sum[SumW-1:0];
    res.taken = cnt[TakenW-1:0];
    res.dropped = ovf;
    return res;
  endfunction

  // Offer one edge; valid stays high across back-to-back transactions.
  task automatic send_edge(input logic [5:0] a, input logic [5:0] b,
                           input logic [15:0] w, input bit last);
    span_edge_t e;
    bit         rdy;
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, w, b, a};
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    e = '{a: a, b: b, w: w};
    edges_sent++;
    if (graph_q.size() < Capacity) graph_q = {graph_q, e};
    else graph_overflow = 1'b1;
    if (last) begin
      forest_q = {forest_q, kruskal_forest(graph_q, graph_overflow, vcount_cfg)};
      graph_q.delete();
      graph_overflow = 1'b0;
      graphs_sent++;
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (forest_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write vertex_count while the block is idle.
  task automatic set_vcount(input logic [6:0] vc);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= vc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_cfg = vc;
  endtask

  // Random graph; well formed unless noisy, in which case endpoints span 0..63.
  task automatic send_graph(input int n, input bit noisy);
    int nv;
    logic [5:0] a, b;
    nv = (vcount_cfg == 0) ? 1 : (vcount_cfg > 64) ? 64 : int'(vcount_cfg);
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end else begin
        a = $urandom_range(nv - 1);
        b = $urandom_range(nv - 1);
      end
      send_edge(a, b, ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
                i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_vcount(7'd64);
    send_edge(6'd0, 6'd63, 16'hFFFF, 1'b1);
    send_edge(6'd5, 6'd5, 16'd3, 1'b1);            // self loop only
    send_edge(6'd0, 6'd1, 16'd9, 1'b0);            // ties on weight, cycle
    send_edge(6'd1, 6'd2, 16'd9, 1'b0);
    send_edge(6'd2, 6'd0, 16'd9, 1'b0);
    send_edge(6'd63, 6'd62, 16'hFFFF, 1'b0);
    send_edge(6'd62, 6'd61, 16'd0, 1'b1);
    set_vcount(7'd5);                              // endpoints out of range get skipped
    send_edge(6'd4, 6'd5, 16'd1, 1'b0);
    send_edge(6'd0, 6'd4, 16'd2, 1'b0);
    send_edge(6'd63, 6'd0, 16'd3, 1'b1);
    set_vcount(7'd0);                              // acts as one vertex
    send_edge(6'd0, 6'd1, 16'd4, 1'b0);
    send_edge(6'd0, 6'd0, 16'd4, 1'b1);
    set_vcount(7'd127);                            // clamps to the maximum
    for (int i = 0; i < 8; i++)
      send_edge(6'(i * 9), 6'(63 - i * 7), 16'hFFFF - 16'(i), i == 7);
    set_vcount(7'd1);
    send_edge(6'd0, 6'd0, 16'd1, 1'b1);
  endtask

  // Fill past capacity, reverse sorted, dropped last edge; then a normal graph.
  task automatic test_capacity();
    set_vcount(7'd64);
    for (int i = 0; i < Capacity + 4; i++)
      send_edge(6'($urandom_range(63)), 6'($urandom_range(63)), 16'(60000 - i * 200),
                i == Capacity + 3);
    send_graph(6, 1'b0);
  endtask

  // Hold the output a long time while more graphs are offered.
  task automatic test_backpressure();
    set_vcount(7'd16);
    hold_cycles = 600;
    for (int g = 0; g < 4; g++) send_graph(8, 1'b0);
  endtask

  task automatic test_random();
    int phase;
    phase = 0;
    while (edges_sent < 1450) begin
      case (phase % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 80; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 80; end
        default: begin src_idle = 32; snk_stall = 32; end
      endcase
      case ($urandom_range(5))
        0: set_vcount(7'd64);
        1: set_vcount(7'd2);
        2: set_vcount(7'($urandom_range(127)));
        default: set_vcount(7'($urandom_range(1, 64)));
      endcase
      for (int g = 0; g < 8; g++)
        send_graph(($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16),
                   $urandom_range(9) < 2);
      phase++;
    end
    src_idle = 0;
    snk_stall = 0;
  endtask

  // Result side: random stall, long hold when requested, check each transaction.
  always @(negedge clk_i) begin
    in_hs    <= s_axis_tvalid && s_axis_tready;
    out_hs   <= m_axis_tvalid && m_axis_tready;
    out_data <= m_axis_tdata;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    forest_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_hs) begin
        got = '{total: out_data[21:0], taken: out_data[27:22], dropped: out_data[28]};
        results_seen++;
        if (forest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = forest_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (in_hs || out_hs || !rst_ni) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("tb_kruskal_mst_weight_core NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    vcount_cfg = 7'd64;
    graph_overflow = 1'b0;
    src_idle = 0;
    snk_stall = 0;
    hold_cycles = 0;
    mismatches = 0;
    results_seen = 0;
    edges_sent = 0;
    graphs_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d edges in %0d graphs, %0d results checked", edges_sent,
             graphs_sent, results_seen);
    $display("vertex count extremes, overflow, self loops, out-of-range ends, stalls");
    if (mismatches == 0 && forest_q.size() == 0) begin
      $display("tb_kruskal_mst_weight_core OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, forest_q.size());
      $display("tb_kruskal_mst_weight_core NOT OK");
    end
    $finish;
  end

endmodule
